// File: rtl/core/ros_pkg.sv
`timescale 1ns / 1ps

package ros_pkg;

  // Default sizes, handed to the top level parameters
  localparam int VALUE_BITS_DEF  = 10;
  localparam int MAX_ITEMS_DEF   = 1024;
  localparam int ORDER_DEPTH_DEF = 1024;

  // Function codes of an input transaction
  typedef enum logic [1:0] {
    FUNC_ORDER = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_PULL  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ORDER_UPD,
    ST_DATA_UPD,
    ST_LIST_CNT,
    ST_LIST_CHK,
    ST_UNL_CHK,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_start;   // reset length, total, flag and cursor
    logic clr_step;    // zero one count/mark entry
    logic ld_read;     // read count entry at item_value
    logic order_upd;   // finish an order load
    logic data_upd;    // finish a data load
    logic list_read;   // read order list at cursor
    logic list_cnt;    // read count of the listed value just fetched
    logic list_next;   // listed entry empty, advance cursor
    logic unl_start;   // begin or resume unlisted scan
    logic unl_next;    // unlisted value empty, advance cursor
    logic take;        // use up one of the current value
    logic set_empty;   // prepare an empty result
    logic emit;        // move pending result into the output register
  } ros_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic none_left;
    logic start_listed;
    logic list_hit;
    logic list_end;
    logic unl_hit;
    logic out_free;
  } ros_sts_t;

endpackage

// File: rtl/core/ros_ram.sv
`timescale 1ns / 1ps

module ros_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ros_ctrl.sv
`timescale 1ns / 1ps

module ros_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  ros_pkg::ros_sts_t sts,
  output ros_pkg::ros_cmd_t cmd
);

  import ros_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (func)
            FUNC_ORDER: begin
              cmd.ld_read = 1'b1;
              state_next  = ST_ORDER_UPD;
            end
            FUNC_DATA: begin
              cmd.ld_read = 1'b1;
              state_next  = ST_DATA_UPD;
            end
            FUNC_PULL: begin
              if (sts.none_left) begin
                cmd.set_empty = 1'b1;
                state_next    = ST_EMIT;
              end else if (sts.start_listed) begin
                cmd.list_read = 1'b1;
                state_next    = ST_LIST_CNT;
              end else begin
                cmd.unl_start = 1'b1;
                state_next    = ST_UNL_CHK;
              end
            end
            default: begin
              cmd.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
          endcase
        end
      end
      ST_ORDER_UPD: begin
        cmd.order_upd = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_DATA_UPD: begin
        cmd.data_upd = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_LIST_CNT: begin
        cmd.list_cnt = 1'b1;
        state_next   = ST_LIST_CHK;
      end
      ST_LIST_CHK: begin
        if (sts.list_hit) begin
          cmd.take   = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.list_next = 1'b1;
          state_next    = sts.list_end ? ST_UNL_CHK : ST_LIST_CNT;
        end
      end
      ST_UNL_CHK: begin
        if (sts.unl_hit) begin
          cmd.take   = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.unl_next = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/ros_dp.sv
`timescale 1ns / 1ps

module ros_dp #(
  parameter int VALUE_BITS  = ros_pkg::VALUE_BITS_DEF,
  parameter int MAX_ITEMS   = ros_pkg::MAX_ITEMS_DEF,
  parameter int ORDER_DEPTH = ros_pkg::ORDER_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] item_value,
  input  ros_pkg::ros_cmd_t     cmd,
  output ros_pkg::ros_sts_t     sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_value,
  output logic                  last,
  output logic                  empty_res,
  output logic                  overflow
);

  import ros_pkg::*;

  localparam int NV  = 1 << VALUE_BITS;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int OLW = $clog2(ORDER_DEPTH + 1);
  localparam int OAW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
  localparam int PW  = (VALUE_BITS > OLW) ? VALUE_BITS : OLW;
  localparam int TW  = VALUE_BITS + CW;
  localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_ITEMS);
  localparam logic [OLW-1:0] LEN_MAX = OLW'(ORDER_DEPTH);

  // count store: {listed mark, count}
  logic                  cnt_we;
  logic [VALUE_BITS-1:0] cnt_waddr;
  logic [CW:0]           cnt_wdata;
  logic [VALUE_BITS-1:0] cnt_raddr;
  logic [CW:0]           cnt_rdata;

  logic                  ord_we;
  logic [OAW-1:0]        ord_raddr;
  logic [VALUE_BITS-1:0] ord_rdata;

  logic [VALUE_BITS-1:0] cur_val;
  logic [VALUE_BITS-1:0] clr_ptr;
  logic [OLW-1:0]        order_length;
  logic [TW-1:0]         total;
  logic                  ovf_flag;
  logic                  phase;       // 0 listed, 1 unlisted
  logic [PW-1:0]         ptr;
  logic [PW-1:0]         ptr_inc;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_last;
  logic                  res_empty;

  logic [CW-1:0] cur_cnt;
  logic          cur_mark;
  logic          list_end;

  assign cur_cnt  = cnt_rdata[CW-1:0];
  assign cur_mark = cnt_rdata[CW];
  assign ptr_inc  = ptr + PW'(1);
  assign list_end = ((PW + 1)'(ptr) + (PW + 1)'(1)) >= (PW + 1)'(order_length);

  assign sts.clr_last     = (clr_ptr == VALUE_BITS'(NV - 1));
  assign sts.none_left    = (total == '0);
  assign sts.start_listed = !phase && ((PW + 1)'(ptr) < (PW + 1)'(order_length));
  assign sts.list_hit     = (cur_cnt != '0);
  assign sts.list_end     = list_end;
  assign sts.unl_hit      = !cur_mark && (cur_cnt != '0);
  assign sts.out_free     = !out_valid || out_ready;

  // read address select; cur_val tracks the address of cnt_rdata
  always_comb begin
    cnt_raddr = cur_val;
    ord_raddr = ptr[OAW-1:0];
    if (cmd.ld_read) begin
      cnt_raddr = item_value;
    end else if (cmd.list_read) begin
      ord_raddr = ptr[OAW-1:0];
    end else if (cmd.list_cnt) begin
      cnt_raddr = ord_rdata;
    end else if (cmd.unl_start) begin
      cnt_raddr = phase ? ptr[VALUE_BITS-1:0] : '0;
    end else if (cmd.list_next) begin
      cnt_raddr = '0;
      ord_raddr = ptr_inc[OAW-1:0];
    end else if (cmd.unl_next) begin
      cnt_raddr = ptr_inc[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cur_val;
    cnt_wdata = cnt_rdata;
    ord_we    = 1'b0;
    if (cmd.clr_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_ptr;
      cnt_wdata = '0;
    end else if (cmd.order_upd) begin
      if (!cur_mark && (order_length < LEN_MAX)) begin
        cnt_we    = 1'b1;
        cnt_wdata = {1'b1, cur_cnt};
        ord_we    = 1'b1;
      end
    end else if (cmd.data_upd) begin
      if (cur_cnt < CNT_MAX) begin
        cnt_we    = 1'b1;
        cnt_wdata = {cur_mark, cur_cnt + CW'(1)};
      end
    end else if (cmd.take) begin
      cnt_we    = 1'b1;
      cnt_wdata = {cur_mark, cur_cnt - CW'(1)};
    end
  end

  ros_ram #(
    .WIDTH (CW + 1),
    .DEPTH (NV)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  ros_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ORDER_DEPTH)
  ) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (order_length[OAW-1:0]),
    .wdata (cur_val),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  always_ff @(posedge clk) begin
    cur_val <= cnt_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      order_length <= '0;
      total        <= '0;
      ovf_flag     <= 1'b0;
      phase        <= 1'b0;
      ptr          <= '0;
    end else begin
      if (cmd.order_upd) begin
        phase <= 1'b0;
        ptr   <= '0;
        if (!cur_mark) begin
          if (order_length < LEN_MAX) begin
            order_length <= order_length + OLW'(1);
          end else begin
            ovf_flag <= 1'b1;
          end
        end
      end
      if (cmd.data_upd) begin
        phase <= 1'b0;
        ptr   <= '0;
        if (cur_cnt < CNT_MAX) begin
          total <= total + TW'(1);
        end else begin
          ovf_flag <= 1'b1;
        end
      end
      if (cmd.unl_start && !phase) begin
        phase <= 1'b1;
        ptr   <= '0;
      end
      if (cmd.list_next) begin
        if (list_end) begin
          phase <= 1'b1;
          ptr   <= '0;
        end else begin
          ptr <= ptr_inc;
        end
      end
      if (cmd.unl_next) begin
        ptr <= ptr_inc;
      end
      if (cmd.take) begin
        total <= total - TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_step) begin
      clr_ptr <= clr_ptr + VALUE_BITS'(1);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_value <= cur_val;
      res_last  <= (total == TW'(1));
      res_empty <= 1'b0;
    end else if (cmd.set_empty) begin
      res_value <= '0;
      res_last  <= 1'b0;
      res_empty <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value <= res_value;
      last      <= res_last;
      empty_res <= res_empty;
      overflow  <= ovf_flag;
    end
  end

`ifndef SYNTHESIS
  a_take_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (cur_cnt != '0) && (total != '0))
    else $error("take on an empty count");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (order_length <= LEN_MAX))
    else $error("order length past depth");

  a_last_total: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && (total == TW'(1))) |=> (total == '0))
    else $error("last value left a count");
`endif

endmodule

// File: rtl/core/relative_order_sort_unit.sv
`timescale 1ns / 1ps
// Relative-order counting sort.
// Input channel (in_valid/in_ready, func, item_value): each transaction is
//   FUNC_ORDER  append a distinct value to the priority list (repeats ignored)
//   FUNC_DATA   add one to the count of a value (saturates, sets overflow)
//   FUNC_PULL   take the next value of the sorted run
//   FUNC_CLEAR  empty all stores and drop the overflow flag
// Output channel (out_valid/out_ready): one transaction per pull only, with
//   out_value, last (no counts left after it), empty_res (nothing to pull),
//   and the sticky overflow flag.
// Steps: an order or data load is a read-modify-write on the count RAM; a
//   pull with nothing left gives an empty result, else it walks the listed
//   entries in list order, then scans the unlisted values upward. The scan
//   walks the count RAM one entry per cycle. Clear zeroes every count entry.
//   The result goes to a pending register and, once the output register is
//   free, sits in the output register.
// Reset runs the same clearing pass, with in_ready low.
// A stalled receiver holds the output register; loads are still taken, and
//   a pull finishes its scan and then waits until the register frees.
module relative_order_sort_unit #(
  parameter int VALUE_BITS  = ros_pkg::VALUE_BITS_DEF,
  parameter int MAX_ITEMS   = ros_pkg::MAX_ITEMS_DEF,
  parameter int ORDER_DEPTH = ros_pkg::ORDER_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [VALUE_BITS-1:0] item_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_value,
  output logic                  last,
  output logic                  empty_res,
  output logic                  overflow
);

  import ros_pkg::*;

  ros_cmd_t cmd;
  ros_sts_t sts;

  // sequencing: load, scan and clear steps
  ros_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .sts      (sts),
    .cmd      (cmd)
  );

  // count/mark RAM, order list RAM, cursor and output register
  ros_dp #(
    .VALUE_BITS  (VALUE_BITS),
    .MAX_ITEMS   (MAX_ITEMS),
    .ORDER_DEPTH (ORDER_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_value (item_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .last       (last),
    .empty_res  (empty_res),
    .overflow   (overflow)
  );

endmodule
